/* rtl/gvd_pkg.sv */
// shared types, constants and helpers of the grouped varint delta decoder
`timescale 1ns / 1ps
package gvd_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 31;
  localparam int unsigned PosW    = 48;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CtrlW   = 30;  // ten 3-bit size fields
  localparam int unsigned SlotW   = 4;
  localparam int unsigned SizeW   = 4;

  // defaults for the top level parameters
  localparam int unsigned GroupValues = 10;
  localparam int unsigned MaxGroup    = 10;
  localparam int unsigned MidDepth    = 4;
  localparam int unsigned OutDepth    = 2;

  // control word is four bytes long
  localparam logic [3:0] CtrlBytes = 4'd4;

  // completed payload handed from front to back
  typedef struct packed {
    logic [ValueW-1:0] delta;
    logic              first;
    logic              last;
    logic [PosW-1:0]   end_pos;
  } delta_rec_t;

  // finished result beat
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
    logic [PosW-1:0]   end_pos;
  } result_t;

  // payload size (1 to 8) of a slot, slot taken modulo ten
  function automatic logic [SizeW-1:0] size_of_slot(input logic [CtrlW-1:0] cb,
                                                    input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] s;
    logic [4:0]       shamt;
    logic [CtrlW-1:0] sh;
    s     = (slot >= 4'(MaxGroup)) ? slot - 4'(MaxGroup) : slot;
    shamt = {s, 1'b0} + {1'b0, s};
    sh    = cb >> shamt;
    return {1'b0, sh[2:0]} + 4'd1;
  endfunction

endpackage

/* rtl/grouped_varint_delta_decoder_unit.sv */
// top level of the grouped varint delta decoder
//
// Input channel: one byte of a compressed run per beat, taken when push is
// high and full low. A beat with run_start_i high begins a run and carries
// its value count and start offset; it abandons any run in progress.
// Beats that arrive with no run open are dropped.
// Result channel: one decoded value per completed payload, shown while
// empty is low and taken when pop is high. The last value of a run has
// last_value_o set and end_position_o holding the byte position after it.
// Throughput is one byte per cycle while full is low. The front parser
// handles a byte in the cycle it is taken; the back stage adds the 64-bit
// delta as it moves from the middle queue into the result queue.
// When pop stays low the result queue fills, then the middle queue, and
// full rises once both are full; no beat is lost.
// Reset empties both queues and leaves the parser idle, waiting for a start.
`timescale 1ns / 1ps
module grouped_varint_delta_decoder_unit #(
  parameter int unsigned GROUP_VALUES = gvd_pkg::GroupValues,
  parameter int unsigned MID_DEPTH    = gvd_pkg::MidDepth,
  parameter int unsigned OUT_DEPTH    = gvd_pkg::OutDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [gvd_pkg::ByteW-1:0]  data_byte_i,
  input  logic                       run_start_i,
  input  logic [gvd_pkg::CountW-1:0] run_count_i,
  input  logic [gvd_pkg::PosW-1:0]   start_offset_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [gvd_pkg::ValueW-1:0] decoded_value_o,
  output logic                       last_value_o,
  output logic [gvd_pkg::PosW-1:0]   end_position_o
);

  logic                accept;
  logic                rec_valid;
  logic                rec_pop;
  logic                rec_empty;
  gvd_pkg::delta_rec_t rec_in;
  gvd_pkg::delta_rec_t rec_out;
  logic [$bits(gvd_pkg::delta_rec_t)-1:0] rec_raw;
  gvd_pkg::result_t    res;

  assign accept = push && !full;

  // front: parse the byte stream
  gvd_front #(
    .GROUP_VALUES (GROUP_VALUES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .run_start_i    (run_start_i),
    .run_count_i    (run_count_i),
    .start_offset_i (start_offset_i),
    .rec_valid_o    (rec_valid),
    .rec_o          (rec_in)
  );

  // queue of completed deltas between front and back
  gvd_fifo #(
    .WIDTH ($bits(gvd_pkg::delta_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .wdata_i (rec_in),
    .pop_i   (rec_pop),
    .rdata_o (rec_raw),
    .full_o  (full),
    .empty_o (rec_empty)
  );

  assign rec_out = gvd_pkg::delta_rec_t'(rec_raw);

  // back: running sum and result queue
  gvd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign decoded_value_o = res.value;
  assign last_value_o    = res.last;
  assign end_position_o  = res.end_pos;

endmodule

/* rtl/gvd_fifo.sv */
// small register queue used between the decoder stages and at the output
`timescale 1ns / 1ps
module gvd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // status and head beat
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/gvd_front.sv */
// byte parser: control words, payload bytes, run bookkeeping
`timescale 1ns / 1ps
module gvd_front #(
  parameter int unsigned GROUP_VALUES = gvd_pkg::GroupValues
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [gvd_pkg::ByteW-1:0]     data_byte_i,
  input  logic                          run_start_i,
  input  logic [gvd_pkg::CountW-1:0]    run_count_i,
  input  logic [gvd_pkg::PosW-1:0]      start_offset_i,
  output logic                          rec_valid_o,
  output gvd_pkg::delta_rec_t           rec_o
);

  logic                          busy_q, busy_d, e_busy;
  logic                          incw_q, incw_d, e_incw;
  logic                          first_q, first_d, e_first;
  logic [gvd_pkg::CtrlW-1:0]     cb_q, cb_d, e_cb;
  logic [2:0]                    bi_q, bi_d, e_bi;
  logic [gvd_pkg::SizeW-1:0]     ps_q, ps_d, e_ps;
  logic [gvd_pkg::ValueW-1:0]    da_q, da_d, e_da;
  logic [gvd_pkg::SlotW-1:0]     gs_q, gs_d, e_gs;
  logic [gvd_pkg::CountW-1:0]    vl_q, vl_d, e_vl;
  logic [gvd_pkg::PosW-1:0]      pos_q, pos_d, e_pos;

  logic                          fresh;
  logic [3:0]                    nxt;
  logic [31:0]                   cb_word;
  logic [gvd_pkg::ValueW-1:0]    da_new;
  logic [gvd_pkg::SlotW-1:0]     gs_n;

  // a start beat reloads the run state before the byte is parsed
  assign fresh   = accept_i && run_start_i;
  assign e_busy  = fresh ? (run_count_i != '0) : busy_q;
  assign e_incw  = fresh ? 1'b1 : incw_q;
  assign e_first = fresh ? 1'b1 : first_q;
  assign e_cb    = fresh ? '0 : cb_q;
  assign e_bi    = fresh ? '0 : bi_q;
  assign e_ps    = fresh ? '0 : ps_q;
  assign e_da    = fresh ? '0 : da_q;
  assign e_gs    = fresh ? '0 : gs_q;
  assign e_vl    = fresh ? run_count_i : vl_q;
  assign e_pos   = fresh ? start_offset_i : pos_q;

  // per byte parsing
  always_comb begin
    busy_d  = e_busy;
    incw_d  = e_incw;
    first_d = e_first;
    cb_d    = e_cb;
    bi_d    = e_bi;
    ps_d    = e_ps;
    da_d    = e_da;
    gs_d    = e_gs;
    vl_d    = e_vl;
    pos_d   = e_pos;
    nxt     = {1'b0, e_bi} + 4'd1;
    cb_word = {2'b00, e_cb} | ({24'd0, data_byte_i} << {e_bi[1:0], 3'b000});
    da_new  = e_da | ({56'd0, data_byte_i} << {e_bi, 3'b000});
    gs_n    = e_gs + gvd_pkg::SlotW'(1);
    rec_valid_o   = 1'b0;
    rec_o.delta   = da_new;
    rec_o.first   = e_first;
    rec_o.last    = 1'b0;
    rec_o.end_pos = '0;
    if (accept_i && e_busy) begin
      pos_d = e_pos + gvd_pkg::PosW'(1);
      if (e_incw) begin
        cb_d = cb_word[gvd_pkg::CtrlW-1:0];
        if (nxt >= gvd_pkg::CtrlBytes) begin
          incw_d = 1'b0;
          bi_d   = '0;
          gs_d   = '0;
          ps_d   = gvd_pkg::size_of_slot(cb_word[gvd_pkg::CtrlW-1:0], '0);
        end else begin
          bi_d = nxt[2:0];
        end
      end else if (nxt < {1'b0, e_ps[2:0]} + {3'd0, e_ps[3]} * 4'd8) begin
        da_d = da_new;
        bi_d = nxt[2:0];
      end else begin
        // payload complete: hand the delta to the back stage
        rec_valid_o = 1'b1;
        first_d     = 1'b0;
        da_d        = '0;
        bi_d        = '0;
        vl_d        = e_vl - gvd_pkg::CountW'(1);
        if (vl_d == '0) begin
          rec_o.last    = 1'b1;
          rec_o.end_pos = pos_d;
          busy_d = 1'b0;
          incw_d = 1'b1;
          cb_d   = '0;
          gs_d   = '0;
          ps_d   = '0;
        end else if (gs_n >= gvd_pkg::SlotW'(GROUP_VALUES)) begin
          incw_d = 1'b1;
          cb_d   = '0;
          gs_d   = '0;
          ps_d   = '0;
        end else begin
          gs_d = gs_n;
          ps_d = gvd_pkg::size_of_slot(e_cb, gs_n);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      incw_q  <= 1'b1;
      first_q <= 1'b0;
      cb_q    <= '0;
      bi_q    <= '0;
      ps_q    <= '0;
      da_q    <= '0;
      gs_q    <= '0;
      vl_q    <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      busy_q  <= busy_d;
      incw_q  <= incw_d;
      first_q <= first_d;
      cb_q    <= cb_d;
      bi_q    <= bi_d;
      ps_q    <= ps_d;
      da_q    <= da_d;
      gs_q    <= gs_d;
      vl_q    <= vl_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* rtl/gvd_back.sv */
// delta summation into the running value and result queue
`timescale 1ns / 1ps
module gvd_back #(
  parameter int unsigned OUT_DEPTH = gvd_pkg::OutDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rec_empty_i,
  input  gvd_pkg::delta_rec_t         rec_i,
  output logic                        rec_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output gvd_pkg::result_t            res_o
);

  logic [gvd_pkg::ValueW-1:0] sum_q, sum_d;
  logic                       out_full;
  gvd_pkg::result_t           res_in;
  logic [$bits(gvd_pkg::result_t)-1:0] res_raw;

  // take a delta whenever the result queue has room
  assign rec_pop_o = !rec_empty_i && !out_full;

  // a run restarts the sum from zero
  always_comb begin
    sum_d = (rec_i.first ? '0 : sum_q) + rec_i.delta;
    res_in.value   = sum_d;
    res_in.last    = rec_i.last;
    res_in.end_pos = rec_i.end_pos;
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      sum_q <= sum_d;
    end
  end

  gvd_fifo #(
    .WIDTH ($bits(gvd_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_pop_o),
    .wdata_i (res_in),
    .pop_i   (pop_i),
    .rdata_o (res_raw),
    .full_o  (out_full),
    .empty_o (empty_o)
  );

  assign res_o = gvd_pkg::result_t'(res_raw);

endmodule

/* rtl/gvd_checker.sv */
// port level checks of the decoder and their binding
`timescale 1ns / 1ps
module gvd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [gvd_pkg::ValueW-1:0] decoded_value_o,
  input logic                       last_value_o,
  input logic [gvd_pkg::PosW-1:0]   end_position_o
);

  // end position only on the last value of a run
  a_pos_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_value_o) |-> (end_position_o == '0))
    else $error("end position set on a value that is not last");

  // a waiting result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(decoded_value_o)
                          && $stable(last_value_o) && $stable(end_position_o)))
    else $error("waiting result beat changed");

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // no result can show up the cycle right after reset release
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!rst_ni) && rst_ni) |=> empty)
    else $error("result beat appeared too early after reset");

endmodule

bind grouped_varint_delta_decoder_unit gvd_checker u_gvd_checker (.*);

/* tb/gvd_decode_checker.sv */
// checker that predicts decoded values from the byte stream and compares result beats
`timescale 1ns / 1ps
module gvd_decode_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       full_i,
  input  logic [gvd_pkg::ByteW-1:0]  data_byte_i,
  input  logic                       run_start_i,
  input  logic [gvd_pkg::CountW-1:0] run_count_i,
  input  logic [gvd_pkg::PosW-1:0]   start_offset_i,
  input  logic                       empty_i,
  input  logic                       pop_i,
  input  logic [gvd_pkg::ValueW-1:0] decoded_value_i,
  input  logic                       last_value_i,
  input  logic [gvd_pkg::PosW-1:0]   end_position_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int unsigned GroupLen = gvd_pkg::GroupValues;
  localparam int          ReportMax = 10;

  // parser state of the predicted decoder
  logic                          run_open;
  logic                          in_ctrl;
  logic [31:0]                   ctrl_word;
  logic [2:0]                    byte_idx;
  logic [3:0]                    pay_size;
  logic [gvd_pkg::ValueW-1:0]    delta_acc;
  logic [3:0]                    slot;
  logic [gvd_pkg::CountW-1:0]    remaining;
  logic [gvd_pkg::ValueW-1:0]    total;
  logic [gvd_pkg::PosW-1:0]      pos;

  // decoded values still to come out of the block
  gvd_pkg::result_t expected_values[$];
  int errors = 0;

  // payload length in bytes of a slot of the current group
  function automatic logic [3:0] slot_bytes(input logic [31:0] cw, input logic [3:0] s);
    int unsigned field;
    field = (cw >> (3 * (s % 10))) & 32'd7;
    return 4'(field + 1);
  endfunction

  task automatic clear_parser();
    run_open  = 1'b0;
    in_ctrl   = 1'b1;
    ctrl_word = '0;
    byte_idx  = '0;
    pay_size  = '0;
    delta_acc = '0;
    slot      = '0;
    remaining = '0;
    total     = '0;
    pos       = '0;
  endtask

  // advance the parser by one accepted byte and queue any completed value
  task automatic decode_beat(input logic [7:0] b_in, input logic st,
                             input logic [gvd_pkg::CountW-1:0] cnt,
                             input logic [gvd_pkg::PosW-1:0] off);
    logic [3:0]       nxt;
    gvd_pkg::result_t res;
    if (st) begin
      clear_parser();
      remaining = cnt;
      pos       = off;
      run_open  = (cnt != '0);
    end
    if (!run_open) return;

    pos = pos + 48'd1;
    nxt = {1'b0, byte_idx} + 4'd1;

    // control word bytes, little endian
    if (in_ctrl) begin
      ctrl_word = ctrl_word | (32'(b_in) << (8 * byte_idx[1:0]));
      if (nxt >= 4'd4) begin
        in_ctrl  = 1'b0;
        byte_idx = '0;
        slot     = '0;
        pay_size = slot_bytes(ctrl_word, 4'd0);
      end else begin
        byte_idx = nxt[2:0];
      end
      return;
    end

    // payload bytes, little endian
    delta_acc = delta_acc | (64'(b_in) << (8 * byte_idx));
    if (nxt < pay_size) begin
      byte_idx = nxt[2:0];
      return;
    end

    total     = total + delta_acc;
    delta_acc = '0;
    byte_idx  = '0;
    remaining = remaining - 31'd1;
    slot      = slot + 4'd1;

    res.value   = total;
    res.last    = 1'b0;
    res.end_pos = '0;

    if (remaining == '0) begin
      res.last    = 1'b1;
      res.end_pos = pos;
      run_open    = 1'b0;
      in_ctrl     = 1'b1;
      ctrl_word   = '0;
      slot        = '0;
      pay_size    = '0;
    end else if (slot >= GroupLen || slot >= 4'd10) begin
      in_ctrl   = 1'b1;
      ctrl_word = '0;
      slot      = '0;
      pay_size  = '0;
    end else begin
      pay_size = slot_bytes(ctrl_word, slot);
    end
    expected_values.push_back(res);
  endtask

  // result beats checked first, then the input beat is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    gvd_pkg::result_t exp_res;
    if (!rst_ni) begin
      clear_parser();
      expected_values.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_values.size() == 0) begin
          if (errors < ReportMax)
            $display("unexpected result beat: value %h last %0d end %h",
                     decoded_value_i, last_value_i, end_position_i);
          errors++;
        end else begin
          exp_res = expected_values.pop_front();
          if (exp_res.value != decoded_value_i || exp_res.last != last_value_i ||
              exp_res.end_pos != end_position_i) begin
            if (errors < ReportMax)
              $display("mismatch: value exp %h got %h, last exp %0d got %0d, end exp %h got %h",
                       exp_res.value, decoded_value_i, exp_res.last, last_value_i,
                       exp_res.end_pos, end_position_i);
            errors++;
          end
        end
      end
      if (push_i && !full_i)
        decode_beat(data_byte_i, run_start_i, run_count_i, start_offset_i);
    end
    pending_o    = expected_values.size();
    fail_count_o = errors;
  end

endmodule

/* tb/tb_grouped_varint_delta_decoder_unit.sv */
// testbench top: clock, reset, byte stream stimulus, result pop pacing and verdict
`timescale 1ns / 1ps
module tb_grouped_varint_delta_decoder_unit;

  localparam int GroupLen    = gvd_pkg::GroupValues;
  localparam int RunBytes    = 830;
  localparam int QuietFrom   = 720;
  localparam int HoldAt      = 400;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 400000;
  localparam int NoLimit     = 32'h7FFF_FFFF;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;
  typedef enum int {CW_RANDOM, CW_LARGE} ctrl_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       push;
  logic                       full;
  logic [gvd_pkg::ByteW-1:0]  data_byte;
  logic                       run_start;
  logic [gvd_pkg::CountW-1:0] run_count;
  logic [gvd_pkg::PosW-1:0]   start_offset;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [gvd_pkg::ValueW-1:0] decoded_value;
  logic                       last_value;
  logic [gvd_pkg::PosW-1:0]   end_position;

  int  fails;
  int  pending;
  int  run_bytes;
  int  cycles = 0;
  int  stall_left = 0;
  bit  quiet;
  bit  calm;
  bit  held;

  grouped_varint_delta_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .run_start_i     (run_start),
    .run_count_i     (run_count),
    .start_offset_i  (start_offset),
    .empty           (empty),
    .pop             (pop),
    .decoded_value_o (decoded_value),
    .last_value_o    (last_value),
    .end_position_o  (end_position)
  );

  gvd_decode_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .data_byte_i    (data_byte),
    .run_start_i    (run_start),
    .run_count_i    (run_count),
    .start_offset_i (start_offset),
    .empty_i        (empty),
    .pop_i          (pop),
    .decoded_value_i(decoded_value),
    .last_value_i   (last_value),
    .end_position_i (end_position),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("grouped_varint_delta_decoder_unit verification failed");
      $finish;
    end
  end

  // result side: random pop stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // one input beat, with an occasional idle burst ahead of it
  task automatic put(input logic [7:0] b_in, input logic st,
                     input logic [gvd_pkg::CountW-1:0] cnt,
                     input logic [gvd_pkg::PosW-1:0] off);
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    push         <= 1'b1;
    data_byte    <= b_in;
    run_start    <= st;
    run_count    <= cnt;
    start_offset <= off;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // send a run of cnt values, cut short after max_bytes bytes
  task automatic send_run(input logic [gvd_pkg::CountW-1:0] cnt,
                          input logic [gvd_pkg::PosW-1:0] off, input int max_bytes,
                          input ctrl_e cmode, input fill_e fmode);
    int          left;
    int          sent;
    int          in_grp;
    int          sz;
    logic [31:0] cw;
    logic [7:0]  pb;
    logic        opening;
    left    = int'(cnt);
    sent    = 0;
    opening = 1'b1;
    while (left > 0 && sent < max_bytes) begin
      // control word, sizes biased toward one or two bytes
      if (cmode == CW_LARGE) begin
        cw = 32'hFFFF_FFFF;
      end else begin
        cw = $urandom;
        for (int k = 0; k < 10; k++)
          if ($urandom_range(0, 2) != 0) cw[3*k +: 3] = {2'b00, cw[3*k]};
      end
      for (int j = 0; j < 4; j++) begin
        if (sent >= max_bytes) break;
        if (opening) put(cw[8*j +: 8], 1'b1, cnt, off);
        else put(cw[8*j +: 8], 1'b0, 31'($urandom), 48'({$urandom, $urandom}));
        opening = 1'b0;
        sent++;
        run_bytes++;
      end
      in_grp = (left < GroupLen) ? left : GroupLen;
      for (int k = 0; k < in_grp; k++) begin
        sz = int'(cw[3*k +: 3]) + 1;
        for (int j = 0; j < sz; j++) begin
          if (sent >= max_bytes) break;
          case (fmode)
            FILL_ONES:  pb = 8'hFF;
            FILL_ZEROS: pb = 8'h00;
            default: begin
              pb = 8'($urandom);
              if ($urandom_range(0, 7) == 0) pb = {8{pb[0]}};
            end
          endcase
          put(pb, 1'b0, 31'($urandom), 48'({$urandom, $urandom}));
          sent++;
          run_bytes++;
        end
        left--;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int                       pick;
    logic [gvd_pkg::CountW-1:0] cnt;
    logic [gvd_pkg::PosW-1:0]   off;
    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte    = '0;
    run_start    = 1'b0;
    run_count    = '0;
    start_offset = '0;
    quiet        = 1'b0;
    calm         = 1'b0;
    held         = 1'b0;
    run_bytes    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: byte with no run open is dropped
    put(8'hA5, 1'b0, 31'd5, 48'd0);
    // directed: largest count, abandoned after two bytes
    send_run(31'h7FFF_FFFF, 48'h0, 2, CW_RANDOM, FILL_RANDOM);
    // directed: zero count start closes the run and stays idle
    put(8'hFF, 1'b1, 31'd0, 48'hFFFF_FFFF_FFFF);
    put(8'h00, 1'b0, 31'h7FFF_FFFF, 48'h0);
    // directed: widest payloads of all ones, sum and position both wrap
    send_run(31'd2, 48'hFFFF_FFFF_FFFD, NoLimit, CW_LARGE, FILL_ONES);

    // random runs, mostly well formed
    while (run_bytes < RunBytes) begin
      if (run_bytes >= QuietFrom) quiet = 1'b1;
      calm = ($urandom_range(0, 5) == 0);
      if (!held && run_bytes >= HoldAt) begin
        held = 1'b1;
        push <= 1'b0;
        while (pending != 0) @(negedge clk_i);
        repeat (8) @(negedge clk_i);
      end
      off = 48'({$urandom, $urandom});
      if ($urandom_range(0, 7) == 0) off = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 40));
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        cnt = ($urandom_range(0, 9) == 0) ? 31'($urandom_range(11, 40))
                                          : 31'($urandom_range(1, 12));
        send_run(cnt, off, NoLimit, CW_RANDOM, FILL_RANDOM);
      end else if (pick < 80) begin
        // broken run, abandoned by whatever starts next
        cnt = 31'($urandom);
        if (cnt == '0) cnt = 31'd1;
        send_run(cnt, off, $urandom_range(1, 30), CW_RANDOM, FILL_RANDOM);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) put(8'($urandom), 1'b0, 31'($urandom), off);
      end else if (pick < 92) begin
        put(8'($urandom), 1'b1, 31'd0, off);
      end else if (pick < 96) begin
        send_run(31'($urandom_range(1, 12)), off, NoLimit, CW_LARGE, FILL_ONES);
      end else begin
        send_run(31'($urandom_range(1, 12)), off, NoLimit, CW_RANDOM, FILL_ZEROS);
      end
    end

    // drain
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("grouped_varint_delta_decoder_unit verification clean");
    end else begin
      $display("grouped_varint_delta_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
